@@ sv/i2c_command_packet_receiver_top_macros.svh @@
// Assertion macros shared by the receiver's RTL.
`ifndef I2C_COMMAND_PACKET_RECEIVER_TOP_MACROS_SVH
`define I2C_COMMAND_PACKET_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define I2C_CPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is high.
`define I2C_CPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/i2c_cpr_pkg.sv @@
package i2c_cpr_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_BYTE     = 2'd0;
  localparam logic [1:0] REQ_STOP     = 2'd1;
  localparam logic [1:0] REQ_TX_EMPTY = 2'd2;
  localparam logic [1:0] REQ_FLASH    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WRITE_CMD   = 2'd0;
  localparam logic [1:0] CFG_STATUS_CMD  = 2'd1;
  localparam logic [1:0] CFG_FULL_LENGTH = 2'd2;
  localparam logic [1:0] CFG_START_ADDR  = 2'd3;

  localparam int unsigned CFG_DATA_W  = 22;
  localparam int unsigned ADDR_W      = 22;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_WRITE_REQ = 3'd1,
    KIND_STATUS    = 3'd2,
    KIND_BAD_CMD   = 3'd3,
    KIND_SEQ_DONE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    APP_WAIT    = 2'd0,
    APP_WRITING = 2'd1,
    APP_DONE    = 2'd2
  } app_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic       flash_ok;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [21:0] dest_address;
    logic [7:0]  word_count;
    logic [1:0]  tx_value;
    logic        sequence_failed;
  } result_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [21:0] dest_address;
    logic [7:0]  word_count;
    logic [1:0]  tx_value;
    logic        sequence_failed;
    logic        last;
  } out_item_t;

  // One queue entry holds every result of one accepted item.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

@@ sv/i2c_cpr_chan_if.sv @@
interface i2c_cpr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/i2c_cpr_front.sv @@
module i2c_cpr_front
  import i2c_cpr_pkg::*;
#(
  parameter int unsigned BUFFER_WORDS = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fire,
  input  in_item_t              item,
  output logic                  push,
  output entry_t                entry
);

  localparam logic [8:0] FULL_BYTES = 9'(2 * BUFFER_WORDS);
  localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(BUFFER_WORDS);

  logic [7:0]        write_cmd, status_cmd, full_code;
  logic [ADDR_W-1:0] start_addr;

  phase_t            phase, phase_next;
  logic [7:0]        length_code, length_code_next;
  logic [8:0]        expected, expected_next;
  logic [8:0]        received, received_next;
  logic [7:0]        held_low, held_low_next;
  app_state_t        app_state, app_state_next;
  logic [ADDR_W-1:0] cur_addr, cur_addr_next;
  logic              pending, pending_next;

  logic              have_word;
  result_t           word_res, req_res, single_res;
  logic [8:0]        len_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_cmd   <= 8'd23;
      status_cmd  <= 8'd32;
      full_code   <= 8'd0;
      start_addr  <= '0;
      phase       <= PH_CMD;
      length_code <= '0;
      expected    <= '0;
      received    <= '0;
      held_low    <= '0;
      app_state   <= APP_WAIT;
      cur_addr    <= '0;
      pending     <= 1'b0;
    end else begin
      phase       <= phase_next;
      length_code <= length_code_next;
      expected    <= expected_next;
      received    <= received_next;
      held_low    <= held_low_next;
      app_state   <= app_state_next;
      pending     <= pending_next;
      cur_addr    <= cur_addr_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WRITE_CMD:   write_cmd  <= cfg_data[7:0];
          CFG_STATUS_CMD:  status_cmd <= cfg_data[7:0];
          CFG_FULL_LENGTH: full_code  <= cfg_data[7:0];
          CFG_START_ADDR:  start_addr <= cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    phase_next       = phase;
    length_code_next = length_code;
    expected_next    = expected;
    received_next    = received;
    held_low_next    = held_low;
    app_state_next   = app_state;
    cur_addr_next    = cur_addr;
    pending_next     = pending;
    push             = 1'b0;
    entry            = '0;
    have_word        = 1'b0;
    word_res         = '0;
    req_res          = '0;
    single_res       = '0;
    len_ext          = {1'b0, item.rx_byte};

    word_res.kind       = KIND_DATA;
    word_res.word_index = received[7:1];
    word_res.word_value = {item.rx_byte, held_low};

    if (fire) begin
      unique case (item.req_type)
        REQ_BYTE: begin
          unique case (phase)
            PH_LEN: begin
              length_code_next = item.rx_byte;
              if (item.rx_byte == full_code || len_ext > FULL_BYTES) begin
                expected_next = FULL_BYTES;
              end else begin
                expected_next = len_ext;
              end
              received_next = '0;
              phase_next    = PH_DATA;
            end
            PH_DATA: begin
              if (received < expected) begin
                if (!received[0]) begin
                  held_low_next = item.rx_byte;
                end else begin
                  have_word = 1'b1;
                end
                received_next = received + 9'd1;
              end
              // The packet closes once the byte count reaches the expected length.
              if (received_next >= expected) begin
                req_res.kind         = KIND_WRITE_REQ;
                req_res.dest_address = cur_addr;
                req_res.word_count   = expected[8:1];
                phase_next           = PH_CMD;
                pending_next         = 1'b1;
                app_state_next       = APP_WRITING;
                push                 = 1'b1;
                if (have_word) begin
                  entry.two    = 1'b1;
                  entry.first  = word_res;
                  entry.second = req_res;
                end else begin
                  entry.first = req_res;
                end
              end else if (have_word) begin
                push        = 1'b1;
                entry.first = word_res;
              end
            end
            default: begin
              phase_next = PH_CMD;
              if (item.rx_byte == write_cmd) begin
                phase_next = PH_LEN;
              end else begin
                push = 1'b1;
                if (item.rx_byte == status_cmd) begin
                  single_res.kind     = KIND_STATUS;
                  single_res.tx_value = app_state;
                end else begin
                  single_res.kind = KIND_BAD_CMD;
                end
                entry.first = single_res;
              end
            end
          endcase
        end
        REQ_STOP: begin
          phase_next    = PH_CMD;
          received_next = '0;
        end
        REQ_TX_EMPTY: begin
          push                = 1'b1;
          single_res.kind     = KIND_STATUS;
          single_res.tx_value = app_state;
          entry.first         = single_res;
        end
        default: begin
          if (pending) begin
            pending_next = 1'b0;
            if (!item.flash_ok || length_code != full_code) begin
              app_state_next             = item.flash_ok ? APP_DONE : APP_WAIT;
              cur_addr_next              = start_addr;
              push                       = 1'b1;
              single_res.kind            = KIND_SEQ_DONE;
              single_res.sequence_failed = !item.flash_ok;
              entry.first                = single_res;
            end else begin
              // A full buffer went out: move on to the next block.
              cur_addr_next = cur_addr + ADDR_STEP;
            end
          end
        end
      endcase
    end

    // A start address write also reloads the running destination address.
    if (cfg_we && cfg_index == CFG_START_ADDR) begin
      cur_addr_next = cfg_data[ADDR_W-1:0];
    end
  end

endmodule

@@ sv/i2c_cpr_fifo.sv @@
module i2c_cpr_fifo
  import i2c_cpr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/i2c_cpr_back.sv @@
module i2c_cpr_back
  import i2c_cpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // Set while the second result of the head entry is on offer.
  logic    second_sel;
  result_t cur;
  logic    is_last;

  assign cur       = second_sel ? head.second : head.first;
  assign is_last   = !head.two || second_sel;
  assign out_valid = !empty;
  assign pop       = out_valid && out_ready && is_last;

  always_comb begin
    out_item.kind            = cur.kind;
    out_item.word_index      = cur.word_index;
    out_item.word_value      = cur.word_value;
    out_item.dest_address    = cur.dest_address;
    out_item.word_count      = cur.word_count;
    out_item.tx_value        = cur.tx_value;
    out_item.sequence_failed = cur.sequence_failed;
    out_item.last            = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_sel <= 1'b0;
    end else if (out_valid && out_ready) begin
      second_sel <= !is_last;
    end
  end

endmodule

@@ sv/i2c_command_packet_receiver_top.sv @@
// Slave-side command deframer for a firmware-update link. Each transaction on rx_in is one
// event (received byte, stop, transmit empty or flash outcome); the block accepts one per
// clock cycle while its four-entry result queue is not full; results are registered in that
// queue and leave on res_out from its head. An event gives zero, one or two results; the
// two-result case (the closing data word of a packet followed by its block-write request)
// leaves as two results in turn, the word first. Input keeps flowing until four events with
// results are waiting behind a stalled output. Configuration writes take effect at the next
// edge; start address writes also reload the running destination address.
`include "i2c_command_packet_receiver_top_macros.svh"

module i2c_command_packet_receiver_top
  import i2c_cpr_pkg::*;
#(
  parameter int unsigned BUFFER_WORDS = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  i2c_cpr_chan_if.sink          rx_in,
  i2c_cpr_chan_if.source        res_out
);

  in_item_t  in_item;
  out_item_t out_item;
  entry_t    q_in, q_head;
  logic      q_push, q_pop, q_full, q_empty;
  logic      in_fire;

  assign in_item.req_type = rx_in.payload.req_type;
  assign in_item.rx_byte  = rx_in.payload.rx_byte;
  assign in_item.flash_ok = rx_in.payload.flash_ok;
  assign rx_in.ready      = !q_full;
  assign in_fire          = rx_in.valid && !q_full;
  assign res_out.payload  = out_item;

  i2c_cpr_front #(
    .BUFFER_WORDS(BUFFER_WORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (in_fire),
    .item     (in_item),
    .push     (q_push),
    .entry    (q_in)
  );

  i2c_cpr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  i2c_cpr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_valid(res_out.valid),
    .out_ready(res_out.ready),
    .out_item (out_item)
  );

  `I2C_CPR_ASSERT_NOW(a_no_overflow, clk, rst, q_push, !q_full,
                      "result queue written while full")
  `I2C_CPR_ASSERT_NOW(a_pair_starts_with_word, clk, rst,
                      res_out.valid && !out_item.last, out_item.kind == KIND_DATA,
                      "non-final result is not a data word")
  `I2C_CPR_ASSERT_NEXT(a_pair_follows, clk, rst,
                       res_out.valid && res_out.ready && !out_item.last,
                       res_out.valid && out_item.kind == KIND_WRITE_REQ && out_item.last,
                       "block write request does not follow its data word")

endmodule
